[src/tcp_pkg.sv]
// Shared types, codes and constants of the 8-bit timer/counter with PWM.
package tcp_pkg;

  localparam int unsigned CountW    = 8;
  localparam int unsigned PrescaleW = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 3;

  localparam logic [CountW-1:0] CountTop    = 8'hFF;
  localparam logic [CountW-1:0] CountBottom = 8'h00;
  localparam logic [CountW-1:0] CountTurn   = 8'hFE;
  localparam logic [CountW-1:0] CountOne    = 8'h01;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_WR_CNT  = 3'd1,
    OP_WR_CMP  = 3'd2,
    OP_CLR_OVF = 3'd3,
    OP_CLR_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_CTC       = 2'd1,
    MODE_FAST_PWM  = 2'd2,
    MODE_PHASE_PWM = 2'd3
  } wave_mode_e;

  typedef enum logic [1:0] {
    ACT_OFF    = 2'd0,
    ACT_TOGGLE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SET    = 2'd3
  } out_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAVE_MODE = 3'd0,
    CFG_OUT_ACT   = 3'd1,
    CFG_CLK_SEL   = 3'd2,
    CFG_OVF_IE    = 3'd3,
    CFG_CMP_IE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    wave_mode_e  mode;
    out_action_e action;
    logic [2:0]  clk_sel;
    logic        ovf_ie;
    logic        cmp_ie;
  } tcp_cfg_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [CountW-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] count_value;
    logic              wave_pin;
    logic              overflow_flag;
    logic              compare_flag;
    logic              irq_request;
  } out_word_t;

  // Low prescaler bits that must be zero for a timer clock, per clock select.
  function automatic logic [PrescaleW-1:0] prescale_mask(input logic [2:0] clk_sel);
    logic [PrescaleW-1:0] m;
    case (clk_sel)
      3'd2:    m = 10'h007;
      3'd3:    m = 10'h01F;
      3'd4:    m = 10'h03F;
      3'd5:    m = 10'h07F;
      3'd6:    m = 10'h0FF;
      3'd7:    m = 10'h3FF;
      default: m = 10'h000;
    endcase
    return m;
  endfunction

endpackage

[src/tcp_stream_if.sv]
// Valid/ready channel that carries one word of a given payload type.
interface tcp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/tcp_prescaler.sv]
// Prescaler counter that turns accepted ticks into timer clock enables.
module tcp_prescaler import tcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic [2:0] clk_sel_i,
  output logic       timer_clk_o
);

  logic [PrescaleW-1:0] count_q, count_d;

  assign count_d     = count_q + PrescaleW'(1);
  assign timer_clk_o = tick_i && ((count_d & prescale_mask(clk_sel_i)) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (tick_i) begin
      count_q <= count_d;
    end
  end

endmodule

[src/tcp_core.sv]
// Counter, compare unit, waveform generator and sticky flags of the timer.
module tcp_core import tcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_word_t    word_i,
  input  logic        timer_clk_i,
  input  tcp_cfg_t    cfg_i,
  output out_word_t   result_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic              dir_q, dir_d;
  logic [CountW-1:0] act_q, act_d;
  logic [CountW-1:0] buf_q, buf_d;
  logic              pin_q, pin_d;
  logic              ovf_q, ovf_d;
  logic              cmp_q, cmp_d;
  logic              pin_off;

  always_comb begin
    cnt_d = cnt_q;
    dir_d = dir_q;
    act_d = act_q;
    buf_d = buf_q;
    pin_d = pin_q;
    ovf_d = ovf_q;
    cmp_d = cmp_q;
    case (word_i.operation)
      OP_TICK: begin
        if (timer_clk_i) begin
          if (cfg_i.mode == MODE_NORMAL || cfg_i.mode == MODE_CTC) begin
            act_d = buf_q;
            dir_d = 1'b0;
            if (cfg_i.mode == MODE_CTC && cnt_q == buf_q) begin
              cnt_d = CountBottom;
            end else begin
              cnt_d = cnt_q + CountOne;
            end
            if (cnt_q == CountTop) ovf_d = 1'b1;
            if (cnt_d == act_d) begin
              cmp_d = 1'b1;
              case (cfg_i.action)
                ACT_TOGGLE: pin_d = ~pin_q;
                ACT_CLEAR:  pin_d = 1'b0;
                ACT_SET:    pin_d = 1'b1;
                default:    pin_d = pin_q;
              endcase
            end
          end else if (cfg_i.mode == MODE_FAST_PWM) begin
            dir_d = 1'b0;
            cnt_d = cnt_q + CountOne;
            // Bottom action first; a match at bottom then overrides it.
            if (cnt_d == CountBottom) begin
              ovf_d = 1'b1;
              if (cfg_i.action == ACT_CLEAR) pin_d = 1'b1;
              else if (cfg_i.action == ACT_SET) pin_d = 1'b0;
            end
            if (cnt_d == CountTop) act_d = buf_q;
            if (cnt_d == act_d) begin
              cmp_d = 1'b1;
              if (cnt_d != CountTop) begin
                if (cfg_i.action == ACT_CLEAR) pin_d = 1'b0;
                else if (cfg_i.action == ACT_SET) pin_d = 1'b1;
              end
            end
          end else begin
            if (!dir_q) begin
              if (cnt_q == CountTop) begin
                dir_d = 1'b1;
                cnt_d = CountTurn;
              end else begin
                cnt_d = cnt_q + CountOne;
              end
            end else begin
              if (cnt_q == CountBottom) begin
                dir_d = 1'b0;
                cnt_d = CountOne;
              end else begin
                cnt_d = cnt_q - CountOne;
              end
            end
            if (cnt_d == CountTop) begin
              dir_d = 1'b1;
              act_d = buf_q;
            end
            if (cnt_d == CountBottom) begin
              dir_d = 1'b0;
              ovf_d = 1'b1;
            end
            // The new direction picks the action, so top and bottom behave right.
            if (cnt_d == act_d) begin
              cmp_d = 1'b1;
              if (cfg_i.action == ACT_CLEAR) pin_d = dir_d;
              else if (cfg_i.action == ACT_SET) pin_d = ~dir_d;
            end
          end
        end
      end
      OP_WR_CNT: cnt_d = word_i.write_value;
      OP_WR_CMP: begin
        buf_d = word_i.write_value;
        if (cfg_i.mode == MODE_NORMAL || cfg_i.mode == MODE_CTC) begin
          act_d = word_i.write_value;
        end
      end
      OP_CLR_OVF: ovf_d = 1'b0;
      OP_CLR_CMP: cmp_d = 1'b0;
      default: ;
    endcase
  end

  assign pin_off = (cfg_i.action == ACT_OFF) ||
                   ((cfg_i.mode == MODE_FAST_PWM || cfg_i.mode == MODE_PHASE_PWM) &&
                    cfg_i.action == ACT_TOGGLE);

  always_comb begin
    result_o.count_value   = cnt_d;
    result_o.wave_pin      = pin_off ? 1'b0 : pin_d;
    result_o.overflow_flag = ovf_d;
    result_o.compare_flag  = cmp_d;
    result_o.irq_request   = (ovf_d & cfg_i.ovf_ie) | (cmp_d & cfg_i.cmp_ie);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dir_q <= 1'b0;
      act_q <= '0;
      buf_q <= '0;
      pin_q <= 1'b0;
      ovf_q <= 1'b0;
      cmp_q <= 1'b0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      dir_q <= dir_d;
      act_q <= act_d;
      buf_q <= buf_d;
      pin_q <= pin_d;
      ovf_q <= ovf_d;
      cmp_q <= cmp_d;
    end
  end

  a_dir_up_outside_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && timer_clk_i && word_i.operation == OP_TICK &&
    cfg_i.mode != MODE_PHASE_PWM |=> !dir_q)
    else $error("direction bit set outside phase-correct mode");

  a_ovf_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.operation == OP_CLR_OVF |=> !ovf_q)
    else $error("overflow flag not cleared");

  a_cmp_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.operation == OP_CLR_CMP |=> !cmp_q)
    else $error("compare flag not cleared");

  a_cmp_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.operation == OP_WR_CMP &&
    (cfg_i.mode == MODE_NORMAL || cfg_i.mode == MODE_CTC) |=> act_q == buf_q)
    else $error("compare write not applied at once in non-PWM mode");

endmodule

[src/timer_counter_8bit_pwm_unit.sv]
// Top level of the 8-bit timer/counter with prescaler, compare unit and PWM output.
// Every accepted word (a tick, a counter or compare write, or a flag clear) gives
// one result word in the next cycle. A new word is taken in every cycle while the
// result side keeps up: the whole step is one pass of compare-and-increment logic
// into the single result register. While a result waits in that register the input
// is held off, so a stalled receiver stalls the sender after one word.
// Configuration writes land in the cycle after cfg_we_i and are meant for idle periods.
module timer_counter_8bit_pwm_unit import tcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tcp_stream_if.sink          in_i,
  tcp_stream_if.source        out_o
);

  tcp_cfg_t  cfg_q;
  out_word_t result;
  out_word_t res_q;
  logic      res_vld_q;
  logic      step;
  logic      tick;
  logic      timer_clk;
  in_word_t  word;

  assign word        = in_i.data;
  assign in_i.ready  = !res_vld_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign tick        = step && (word.operation == OP_TICK) && (cfg_q.clk_sel != 3'd0);
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_NORMAL, action: ACT_OFF, clk_sel: 3'd0,
                 ovf_ie: 1'b0, cmp_ie: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAVE_MODE: cfg_q.mode    <= wave_mode_e'(cfg_data_i[1:0]);
        CFG_OUT_ACT:   cfg_q.action  <= out_action_e'(cfg_data_i[1:0]);
        CFG_CLK_SEL:   cfg_q.clk_sel <= cfg_data_i;
        CFG_OVF_IE:    cfg_q.ovf_ie  <= cfg_data_i[0];
        CFG_CMP_IE:    cfg_q.cmp_ie  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcp_prescaler u_prescaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .clk_sel_i   (cfg_q.clk_sel),
    .timer_clk_o (timer_clk)
  );

  tcp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (word),
    .timer_clk_i (timer_clk),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      res_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

endmodule
